[rtl/dec_pkg.sv]
// ----------------------------------------------------------------------------
// dec_pkg: shared types and constants for the edge insertion cycle checker
// Holds node count, derived widths, request codes and the control structs.
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int NODES = 16;
    localparam int NODE_W = 4;
    localparam int DEPTH_W = $clog2(NODES + 1);
    localparam int CNT_W = 8;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] MARK_NEW = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    typedef struct packed {
        logic clear_graph;
        logic set_edge;
        logic drop_edge;
        logic bump_count;
        logic walk_start;
        logic walk_step;
    } dec_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic cycle;
        logic had_edge;
    } dec_status_t;

endpackage

[rtl/dec_req_if.sv]
// ----------------------------------------------------------------------------
// dec_req_if: request channel
// Valid/ready channel carrying one add or clear request.
// ----------------------------------------------------------------------------
interface dec_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [3:0] from_node;
    logic [3:0] to_node;

    modport source (output valid, req_type, from_node, to_node, input ready);
    modport sink (input valid, req_type, from_node, to_node, output ready);
endinterface

[rtl/dec_rsp_if.sv]
// ----------------------------------------------------------------------------
// dec_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface dec_rsp_if;
    logic valid;
    logic ready;
    logic accepted;
    logic cycle_found;
    logic [7:0] edge_total;

    modport source (output valid, accepted, cycle_found, edge_total, input ready);
    modport sink (input valid, accepted, cycle_found, edge_total, output ready);
endinterface

[rtl/dec_datapath.sv]
// ----------------------------------------------------------------------------
// dec_datapath: graph storage and depth-first walk engine
// Adjacency rows, marks, walk stack and edge counter; one cursor bit per step.
// ----------------------------------------------------------------------------
module dec_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dec_pkg::dec_cmd_t        cmd,
    input  logic [3:0]               from_node,
    input  logic [3:0]               to_node,
    output dec_pkg::dec_status_t     status,
    output logic [7:0]               edge_total
);
    import dec_pkg::*;

    logic [NODES-1:0] adj_reg [NODES];
    logic [1:0] mark_reg [NODES];
    logic [NODE_W-1:0] stk_node_reg [NODES];
    logic [DEPTH_W-1:0] stk_cur_reg [NODES];
    logic [DEPTH_W-1:0] depth_reg;
    logic [NODE_W-1:0] root_reg;
    logic root_end_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic done_reg, cyc_reg;

    logic [NODE_W-1:0] top;
    logic [DEPTH_W-1:0] cur;
    logic [NODE_W-1:0] v;
    logic hit;

    // top of stack; depth is nonzero whenever these are used
    assign top = stk_node_reg[NODE_W'(depth_reg - 1'b1)];
    assign cur = stk_cur_reg[NODE_W'(depth_reg - 1'b1)];
    assign v = cur[NODE_W-1:0];
    assign hit = (cur < DEPTH_W'(NODES)) && adj_reg[top][v];

    assign status.walk_done = done_reg;
    assign status.cycle = cyc_reg;
    assign status.had_edge = adj_reg[from_node][to_node];
    assign edge_total = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                adj_reg[i] <= '0;
                mark_reg[i] <= MARK_NEW;
            end
            cnt_reg <= '0;
            depth_reg <= '0;
            root_reg <= '0;
            root_end_reg <= 1'b0;
            done_reg <= 1'b0;
            cyc_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_graph)
            begin
                for (int i = 0; i < NODES; i++)
                    adj_reg[i] <= '0;
                cnt_reg <= '0;
            end
            if (cmd.set_edge)
                adj_reg[from_node][to_node] <= 1'b1;
            if (cmd.drop_edge)
                adj_reg[from_node][to_node] <= 1'b0;
            if (cmd.bump_count && cnt_reg != '1)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.walk_start)
            begin
                for (int i = 0; i < NODES; i++)
                    mark_reg[i] <= MARK_NEW;
                depth_reg <= '0;
                root_reg <= '0;
                root_end_reg <= 1'b0;
                done_reg <= 1'b0;
                cyc_reg <= 1'b0;
            end
            else if (cmd.walk_step && !done_reg)
            begin
                if (depth_reg == '0)
                begin
                    // pick the next root
                    if (root_end_reg)
                        done_reg <= 1'b1;
                    else
                    begin
                        if (mark_reg[root_reg] == MARK_NEW)
                        begin
                            mark_reg[root_reg] <= MARK_PATH;
                            stk_node_reg[0] <= root_reg;
                            stk_cur_reg[0] <= '0;
                            depth_reg <= DEPTH_W'(1);
                        end
                        root_reg <= root_reg + 1'b1;
                        if (root_reg == NODE_W'(NODES - 1))
                            root_end_reg <= 1'b1;
                    end
                end
                else if (cur >= DEPTH_W'(NODES))
                begin
                    mark_reg[top] <= MARK_DONE;
                    depth_reg <= depth_reg - 1'b1;
                end
                else
                begin
                    stk_cur_reg[NODE_W'(depth_reg - 1'b1)] <= cur + 1'b1;
                    if (hit && mark_reg[v] == MARK_PATH)
                    begin
                        cyc_reg <= 1'b1;
                        done_reg <= 1'b1;
                    end
                    else if (hit && mark_reg[v] == MARK_NEW && depth_reg < DEPTH_W'(NODES))
                    begin
                        mark_reg[v] <= MARK_PATH;
                        stk_node_reg[NODE_W'(depth_reg)] <= v;
                        stk_cur_reg[NODE_W'(depth_reg)] <= '0;
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(NODES))
        else $error("walk stack overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        cyc_reg |-> done_reg)
        else $error("cycle flagged without walk end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bump_count |=> cnt_reg != '0)
        else $error("counter did not rise");
endmodule

[rtl/dec_ctrl.sv]
// ----------------------------------------------------------------------------
// dec_ctrl: request sequencer
// Takes requests, drives the walk engine and holds the result register.
// ----------------------------------------------------------------------------
module dec_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    dec_req_if.sink                  req,
    dec_rsp_if.source                rsp,
    input  dec_pkg::dec_status_t     status,
    input  logic [7:0]               edge_total,
    output dec_pkg::dec_cmd_t        cmd,
    output logic [3:0]               from_node,
    output logic [3:0]               to_node
);
    import dec_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] from_reg, to_reg;
    logic had_reg;
    logic acc_reg, cyc_reg;
    logic take;

    assign take = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.accepted = acc_reg;
    assign rsp.cycle_found = cyc_reg;
    assign rsp.edge_total = edge_total;
    assign from_node = take ? req.from_node : from_reg;
    assign to_node = take ? req.to_node : to_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (req.req_type == REQ_CLEAR)
                    begin
                        cmd.clear_graph = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (req.from_node == req.to_node)
                        state_next = ST_OUT;
                    else
                    begin
                        cmd.set_edge = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.drop_edge = status.cycle;
                cmd.bump_count = !status.cycle && !had_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            from_reg <= req.from_node;
            to_reg <= req.to_node;
            had_reg <= status.had_edge;
            acc_reg <= (req.req_type == REQ_CLEAR);
            cyc_reg <= (req.req_type == REQ_ADD) && (req.from_node == req.to_node);
        end
        if (state_reg == ST_FINISH)
        begin
            acc_reg <= !status.cycle;
            cyc_reg <= status.cycle;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.drop_edge && cmd.bump_count))
        else $error("edge dropped and counted");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.accepted && rsp.cycle_found))
        else $error("accepted with cycle");
endmodule

[rtl/dag_edge_insert_cycle_check.sv]
// ----------------------------------------------------------------------------
// dag_edge_insert_cycle_check: acyclic edge insertion checker
// Adds directed edges only when they keep the graph free of cycles.
// ----------------------------------------------------------------------------
// One request at a time. A clear or self-loop goes straight to its response. An
// add sets the edge and runs a depth-first walk that examines one adjacency bit,
// one root or one stack pop per cycle and stops early when a cycle is met; the
// walk engine's single step unit sets this pace.
// The result register holds until the response transaction completes.
module dag_edge_insert_cycle_check (
    input  logic clk,
    input  logic rst_n,
    dec_req_if.sink req,
    dec_rsp_if.source rsp
);
    import dec_pkg::*;

    dec_cmd_t cmd;
    dec_status_t status;
    logic [7:0] edge_total;
    logic [3:0] from_node, to_node;

    dec_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .status(status),
        .edge_total(edge_total), .cmd(cmd), .from_node(from_node), .to_node(to_node)
    );

    dec_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .from_node(from_node),
        .to_node(to_node), .status(status), .edge_total(edge_total)
    );
endmodule
